// File: src/rsrb_pkg.sv
// Package for the RTP sequence reorder buffer.
// Holds the result status codes, the request function codes and the window register constants.
// No dependencies.
package rsrb_pkg;

   localparam int WIN_BITS = 15;
   localparam logic [WIN_BITS-1:0] WIN_RESET = 15'd1024;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_QUEUED    = 3'd0,
      ST_SIDE      = 3'd1,
      ST_DUP       = 3'd2,
      ST_LATE      = 3'd3,
      ST_FULL      = 3'd4,
      ST_DELIVERED = 3'd5,
      ST_NONE      = 3'd6
   } status_type;

endpackage

// File: src/rsrb_ifaces.sv
// Valid/ready channel interfaces of the RTP sequence reorder buffer.
// Depends on rsrb_pkg for the status type and the window width.
interface rsrb_req_if #(
   parameter int SEQ_BITS = 16,
   parameter int TAG_BITS = 8
);
   import rsrb_pkg::*;
   logic                valid;
   logic                ready;
   logic                func;
   logic [SEQ_BITS-1:0] seq_num;
   logic [TAG_BITS-1:0] tag;
   modport source (output valid, func, seq_num, tag, input ready);
   modport sink (input valid, func, seq_num, tag, output ready);
endinterface

interface rsrb_rsp_if #(
   parameter int SEQ_BITS = 16,
   parameter int TAG_BITS = 8,
   parameter int CNT_BITS = 6
);
   import rsrb_pkg::*;
   logic                valid;
   logic                ready;
   status_type          status;
   logic [SEQ_BITS-1:0] out_seq;
   logic [TAG_BITS-1:0] out_tag;
   logic [CNT_BITS-1:0] flushed;
   logic [CNT_BITS-1:0] held;
   modport source (output valid, status, out_seq, out_tag, flushed, held, input ready);
   modport sink (input valid, status, out_seq, out_tag, flushed, held, output ready);
endinterface

interface rsrb_csr_if;
   import rsrb_pkg::*;
   logic                valid;
   logic                ready;
   logic [WIN_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: src/rtp_sequence_reorder_buffer_unit.sv
// RTP sequence reorder buffer: ordered list and side list kept in two synchronous memories.
// Depends on rsrb_pkg and the channel interfaces in rsrb_ifaces.sv.
//
// Usage: req_ch carries one beat per command: a push (sequence number and payload tag) or a
// pop. Every command yields exactly one beat on rsp_ch with a status, the delivered packet
// on a successful pop, the count of side-list packets discarded, and the number held.
// csr_ch writes the window register at any time it is offered; it is meant to be written
// while the block is idle. Its ready is always high.
// The ordered list is a ring in memory with a head pointer. A push scans the ring one entry
// per cycle from the head, then moves the entries behind the insertion point up one per
// cycle. A pop reads the head entry and loads its result, except when every slot is held
// by the side list: then each side packet is first placed again through the same path.
// The single read port of the ordered memory sets this pace.
// One command is worked on at a time; the next beat can be taken as soon as the previous
// result sits in the output register, even while the receiver stalls it. A stalled output
// holds its beat and blocks the next result only.
// Reset (synchronous) empties both lists, forgets the expected number and sets the window
// to 1024. Memory contents are not cleared; only entries below the list counts are read.
module rtp_sequence_reorder_buffer_unit #(
   parameter int SLOTS    = 32,
   parameter int SEQ_BITS = 16,
   parameter int TAG_BITS = 8
) (
   input logic clock,
   input logic reset,
   rsrb_req_if.sink   req_ch,
   rsrb_rsp_if.source rsp_ch,
   rsrb_csr_if.sink   csr_ch
);
   import rsrb_pkg::*;

   localparam int IW   = $clog2(SLOTS);
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int AW   = CW + 1;
   localparam int CMPW = SEQ_BITS + WIN_BITS;

   typedef struct packed {
      logic [SEQ_BITS-1:0] seq;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PLACE, S_SCAN, S_SHIFT, S_INSERT, S_RP_LOAD, S_POP_WAIT, S_POP, S_RESP
   } state_type;

   function automatic logic [IW-1:0] slot(input logic [IW-1:0] head, input logic [CW-1:0] i);
      logic [AW-1:0] s;
      s = AW'(head) + AW'(i);
      if (s >= AW'(SLOTS)) begin
         s = s - AW'(SLOTS);
      end
      return s[IW-1:0];
   endfunction

   entry_type ord_mem [SLOTS];
   entry_type side_mem [SLOTS];
   entry_type ord_rd_ff, side_rd_ff;

   state_type state_ff, state_in;
   logic [CW-1:0] oc_ff, oc_in, sc_ff, sc_in, idx_ff, idx_in, pos_ff, pos_in;
   logic [CW-1:0] rp_k_ff, rp_k_in, rp_n_ff, rp_n_in, fl_ff, fl_in;
   logic [IW-1:0] head_ff, head_in;
   logic [SEQ_BITS-1:0] exp_ff, exp_in, cur_seq_ff, cur_seq_in;
   logic [TAG_BITS-1:0] cur_tag_ff, cur_tag_in;
   logic expv_ff, expv_in, rp_ff, rp_in;
   logic [WIN_BITS-1:0] win_ff;

   status_type res_status_ff, res_status_in;
   logic [SEQ_BITS-1:0] res_seq_ff, res_seq_in;
   logic [TAG_BITS-1:0] res_tag_ff, res_tag_in;
   logic [CW-1:0] res_fl_ff, res_fl_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [SEQ_BITS-1:0] rsp_seq_ff, rsp_seq_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic [CW-1:0] rsp_fl_ff, rsp_fl_in, rsp_held_ff, rsp_held_in;

   logic ord_we, side_we, pl_done;
   logic [IW-1:0] ord_waddr;
   entry_type ord_wdata, cur_entry;
   status_type pl_code;

   logic [SEQ_BITS-1:0] dist_ahead, dist_behind, dist_head;
   logic [AW-1:0] held_sum;
   logic all_held;

   assign cur_entry   = '{seq: cur_seq_ff, tag: cur_tag_ff};
   assign dist_ahead  = cur_seq_ff - exp_ff;
   assign dist_behind = exp_ff - cur_seq_ff;
   assign dist_head   = ord_rd_ff.seq - cur_seq_ff;
   assign held_sum    = AW'(oc_ff) + AW'(sc_ff);
   assign all_held    = (held_sum == AW'(SLOTS));

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.out_seq = rsp_seq_ff;
   assign rsp_ch.out_tag = rsp_tag_ff;
   assign rsp_ch.flushed = rsp_fl_ff;
   assign rsp_ch.held    = rsp_held_ff;

   always_comb begin
      state_in = state_ff;
      oc_in = oc_ff;
      sc_in = sc_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      rp_k_in = rp_k_ff;
      rp_n_in = rp_n_ff;
      fl_in = fl_ff;
      head_in = head_ff;
      exp_in = exp_ff;
      expv_in = expv_ff;
      rp_in = rp_ff;
      cur_seq_in = cur_seq_ff;
      cur_tag_in = cur_tag_ff;
      res_status_in = res_status_ff;
      res_seq_in = res_seq_ff;
      res_tag_in = res_tag_ff;
      res_fl_in = res_fl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_seq_in = rsp_seq_ff;
      rsp_tag_in = rsp_tag_ff;
      rsp_fl_in = rsp_fl_ff;
      rsp_held_in = rsp_held_ff;
      ord_we = 1'b0;
      ord_waddr = slot(head_ff, '0);
      ord_wdata = cur_entry;
      side_we = 1'b0;
      pl_done = 1'b0;
      pl_code = ST_QUEUED;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.func == FUNC_PUSH) begin
                  cur_seq_in = req_ch.seq_num;
                  cur_tag_in = req_ch.tag;
                  rp_in = 1'b0;
                  if (all_held) begin
                     pl_done = 1'b1;
                     pl_code = ST_FULL;
                  end else begin
                     state_in = S_PLACE;
                  end
               end else begin
                  fl_in = '0;
                  if (oc_ff == '0 && all_held) begin
                     // Every slot sits in the side list: place each side packet again.
                     rp_in = 1'b1;
                     rp_n_in = sc_ff;
                     rp_k_in = '0;
                     sc_in = '0;
                     expv_in = 1'b0;
                     state_in = S_RP_LOAD;
                  end else begin
                     rp_in = 1'b0;
                     idx_in = '0;
                     state_in = S_POP_WAIT;
                  end
               end
            end
         end
         S_PLACE: begin
            if (!expv_ff) begin
               ord_we = 1'b1;
               oc_in = CW'(1);
               exp_in = cur_seq_ff;
               expv_in = 1'b1;
               pl_done = 1'b1;
               pl_code = ST_QUEUED;
            end else if (CMPW'(dist_ahead) < CMPW'(win_ff)) begin
               if (oc_ff == '0) begin
                  ord_we = 1'b1;
                  oc_in = CW'(1);
                  pl_done = 1'b1;
                  pl_code = ST_QUEUED;
               end else begin
                  idx_in = '0;
                  state_in = S_SCAN;
               end
            end else if (dist_behind != '0 && CMPW'(dist_behind) <= CMPW'(win_ff)) begin
               pl_done = 1'b1;
               pl_code = ST_LATE;
            end else begin
               side_we = 1'b1;
               sc_in = CW'(sc_ff + CW'(1));
               pl_done = 1'b1;
               pl_code = ST_SIDE;
            end
         end
         S_SCAN: begin
            // The read data belongs to entry idx; the next entry is read meanwhile.
            if (ord_rd_ff.seq == cur_seq_ff) begin
               pl_done = 1'b1;
               pl_code = ST_DUP;
            end else if (CMPW'(dist_head) < CMPW'(win_ff)) begin
               pos_in = idx_ff;
               idx_in = CW'(oc_ff - CW'(1));
               state_in = S_SHIFT;
            end else if (CW'(idx_ff + CW'(1)) == oc_ff) begin
               ord_we = 1'b1;
               ord_waddr = slot(head_ff, oc_ff);
               oc_in = CW'(oc_ff + CW'(1));
               pl_done = 1'b1;
               pl_code = ST_QUEUED;
            end else begin
               idx_in = CW'(idx_ff + CW'(1));
            end
         end
         S_SHIFT: begin
            ord_we = 1'b1;
            ord_waddr = slot(head_ff, CW'(idx_ff + CW'(1)));
            ord_wdata = ord_rd_ff;
            if (idx_ff == pos_ff) begin
               state_in = S_INSERT;
            end else begin
               idx_in = CW'(idx_ff - CW'(1));
            end
         end
         S_INSERT: begin
            ord_we = 1'b1;
            ord_waddr = slot(head_ff, pos_ff);
            oc_in = CW'(oc_ff + CW'(1));
            pl_done = 1'b1;
            pl_code = ST_QUEUED;
         end
         S_RP_LOAD: begin
            cur_seq_in = side_rd_ff.seq;
            cur_tag_in = side_rd_ff.tag;
            state_in = S_PLACE;
         end
         S_POP_WAIT: begin
            state_in = S_POP;
         end
         S_POP: begin
            rp_in = 1'b0;
            state_in = S_RESP;
            res_status_in = ST_NONE;
            res_seq_in = '0;
            res_tag_in = '0;
            res_fl_in = '0;
            if (oc_ff != '0 && (ord_rd_ff.seq == exp_ff || all_held)) begin
               res_status_in = ST_DELIVERED;
               res_seq_in = ord_rd_ff.seq;
               res_tag_in = ord_rd_ff.tag;
               res_fl_in = CW'(fl_ff + sc_ff);
               head_in = slot(head_ff, CW'(1));
               oc_in = CW'(oc_ff - CW'(1));
               sc_in = '0;
               exp_in = ord_rd_ff.seq + SEQ_BITS'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_seq_in = res_seq_ff;
               rsp_tag_in = res_tag_ff;
               rsp_fl_in = res_fl_ff;
               rsp_held_in = CW'(held_sum);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (pl_done) begin
         if (!rp_ff || state_ff == S_IDLE) begin
            res_status_in = pl_code;
            res_seq_in = '0;
            res_tag_in = '0;
            res_fl_in = '0;
            state_in = S_RESP;
         end else begin
            if (pl_code == ST_DUP || pl_code == ST_LATE || pl_code == ST_FULL) begin
               fl_in = CW'(fl_ff + CW'(1));
            end
            if (CW'(rp_k_ff + CW'(1)) == rp_n_ff) begin
               idx_in = '0;
               state_in = S_POP_WAIT;
            end else begin
               rp_k_in = CW'(rp_k_ff + CW'(1));
               state_in = S_RP_LOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      ord_rd_ff <= ord_mem[slot(head_ff, idx_in)];
      if (side_we) begin
         side_mem[sc_ff[IW-1:0]] <= cur_entry;
      end
      side_rd_ff <= side_mem[rp_k_in[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         oc_ff <= '0;
         sc_ff <= '0;
         head_ff <= '0;
         exp_ff <= '0;
         expv_ff <= 1'b0;
         rp_ff <= 1'b0;
         win_ff <= WIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         oc_ff <= oc_in;
         sc_ff <= sc_in;
         head_ff <= head_in;
         exp_ff <= exp_in;
         expv_ff <= expv_in;
         rp_ff <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            win_ff <= csr_ch.data;
         end
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      rp_k_ff <= rp_k_in;
      rp_n_ff <= rp_n_in;
      fl_ff <= fl_in;
      cur_seq_ff <= cur_seq_in;
      cur_tag_ff <= cur_tag_in;
      res_status_ff <= res_status_in;
      res_seq_ff <= res_seq_in;
      res_tag_ff <= res_tag_in;
      res_fl_ff <= res_fl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seq_ff <= rsp_seq_in;
      rsp_tag_ff <= rsp_tag_in;
      rsp_fl_ff <= rsp_fl_in;
      rsp_held_ff <= rsp_held_in;
   end

endmodule

// File: src/rsrb_check.sv
// Port-level checks for the RTP sequence reorder buffer, attached by a bind statement.
// Depends on rsrb_pkg and on the top level rtp_sequence_reorder_buffer_unit.
module rsrb_check #(
   parameter int SLOTS    = 32,
   parameter int SEQ_BITS = 16,
   parameter int TAG_BITS = 8,
   parameter int CNT_BITS = 6
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [2:0]          rsp_status,
   input logic [SEQ_BITS-1:0] rsp_out_seq,
   input logic [TAG_BITS-1:0] rsp_out_tag,
   input logic [CNT_BITS-1:0] rsp_flushed,
   input logic [CNT_BITS-1:0] rsp_held
);
   import rsrb_pkg::*;

   // A result beat waits until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // One command at a time: the beat after an accepted command is never taken at once.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in work");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_held <= CNT_BITS'(SLOTS))
      else $error("held count above the slot count");

   a_full_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_held == CNT_BITS'(SLOTS))
      else $error("push refused while slots were free");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DELIVERED
      |-> rsp_out_seq == '0 && rsp_out_tag == '0 && rsp_flushed == '0)
      else $error("packet fields set on a beat that delivers nothing");

endmodule

bind rtp_sequence_reorder_buffer_unit rsrb_check #(
   .SLOTS(SLOTS),
   .SEQ_BITS(SEQ_BITS),
   .TAG_BITS(TAG_BITS),
   .CNT_BITS($clog2(SLOTS + 1))
) u_rsrb_check (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_status(rsp_ch.status),
   .rsp_out_seq(rsp_ch.out_seq),
   .rsp_out_tag(rsp_ch.out_tag),
   .rsp_flushed(rsp_ch.flushed),
   .rsp_held(rsp_ch.held)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for rtp_sequence_reorder_buffer_unit: directed and random push/pop traffic.
// Depends on rsrb_pkg, the channel interfaces and the unit in src/.
module tb;
   import rsrb_pkg::*;

   localparam int SLOTS = 32;

   typedef struct packed {
      status_type  status;
      logic [15:0] out_seq;
      logic [7:0]  out_tag;
      logic [5:0]  flushed;
      logic [5:0]  held;
   } reorder_result;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsrb_req_if req_ch ();
   rsrb_rsp_if rsp_ch ();
   rsrb_csr_if csr_ch ();

   rtp_sequence_reorder_buffer_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Shadow of the buffer state.
   logic [15:0] ord_seq [SLOTS];
   logic [7:0]  ord_tag [SLOTS];
   logic [15:0] side_seq [SLOTS];
   logic [7:0]  side_tag [SLOTS];
   int          ord_cnt;
   int          side_cnt;
   int          free_cnt;
   logic [15:0] exp_seq;
   logic        exp_valid;
   int          win;

   reorder_result pending_results[$];
   int fail_count;
   int tx_idle_pct;
   int rx_idle_pct;
   int delivered_count;
   int repush_count;
   int side_count_total;

   task automatic report(input string what);
      fail_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   function automatic status_type place_packet(input logic [15:0] s, input logic [7:0] t);
      int i;
      int j;
      logic [15:0] d;
      logic [15:0] b;
      logic [15:0] e;
      if (!exp_valid) begin
         free_cnt += ord_cnt;
         ord_seq[0] = s;
         ord_tag[0] = t;
         ord_cnt = 1;
         free_cnt--;
         exp_seq = s;
         exp_valid = 1'b1;
         return ST_QUEUED;
      end
      d = s - exp_seq;
      if (int'(d) < win) begin
         for (i = 0; i < ord_cnt; i++) begin
            if (ord_seq[i] == s) return ST_DUP;
            e = ord_seq[i] - s;
            if (e != 0 && int'(e) < win) break;
         end
         if (ord_cnt >= SLOTS) return ST_FULL;
         for (j = ord_cnt; j > i; j--) begin
            ord_seq[j] = ord_seq[j-1];
            ord_tag[j] = ord_tag[j-1];
         end
         ord_seq[i] = s;
         ord_tag[i] = t;
         ord_cnt++;
         free_cnt--;
         return ST_QUEUED;
      end
      b = exp_seq - s;
      if (b >= 1 && int'(b) <= win) return ST_LATE;
      if (side_cnt >= SLOTS) return ST_FULL;
      side_seq[side_cnt] = s;
      side_tag[side_cnt] = t;
      side_cnt++;
      free_cnt--;
      return ST_SIDE;
   endfunction

   function automatic reorder_result predict_command(input func_type f, input logic [15:0] s,
                                                     input logic [7:0] t);
      reorder_result r;
      logic [15:0] tmp_seq [SLOTS];
      logic [7:0]  tmp_tag [SLOTS];
      status_type  st;
      logic [15:0] hs;
      int n;
      int fl;
      int i;
      r = '{status: ST_NONE, out_seq: '0, out_tag: '0, flushed: '0, held: '0};
      fl = 0;
      if (f == FUNC_PUSH) begin
         r.status = (free_cnt == 0) ? ST_FULL : place_packet(s, t);
         if (r.status == ST_SIDE) side_count_total++;
      end else begin
         if (ord_cnt == 0 && free_cnt == 0) begin
            // Side list holds every slot: forget the expected number and place it all again.
            repush_count++;
            n = side_cnt;
            for (i = 0; i < n; i++) begin
               tmp_seq[i] = side_seq[i];
               tmp_tag[i] = side_tag[i];
            end
            side_cnt = 0;
            free_cnt += n;
            exp_valid = 1'b0;
            for (i = 0; i < n; i++) begin
               st = place_packet(tmp_seq[i], tmp_tag[i]);
               if (st == ST_DUP || st == ST_LATE || st == ST_FULL) fl++;
            end
         end
         if (ord_cnt > 0) begin
            hs = ord_seq[0];
            if (hs != exp_seq && free_cnt == 0) exp_seq = hs;
            if (hs == exp_seq) begin
               r.status = ST_DELIVERED;
               r.out_seq = hs;
               r.out_tag = ord_tag[0];
               for (i = 0; i < ord_cnt - 1; i++) begin
                  ord_seq[i] = ord_seq[i+1];
                  ord_tag[i] = ord_tag[i+1];
               end
               ord_cnt--;
               free_cnt++;
               exp_seq = hs + 16'd1;
               fl += side_cnt;
               free_cnt += side_cnt;
               side_cnt = 0;
               delivered_count++;
            end
         end
         if (r.status == ST_DELIVERED) r.flushed = fl[5:0];
      end
      r.held = 6'(SLOTS - free_cnt);
      return r;
   endfunction

   // Sends one beat and predicts its result once it is taken.
   task automatic send_item(input func_type f, input logic [15:0] s, input logic [7:0] t);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.func    <= f;
      req_ch.seq_num <= s;
      req_ch.tag     <= t;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(predict_command(f, s, t));
   endtask

   task automatic push(input logic [15:0] s, input logic [7:0] t);
      send_item(FUNC_PUSH, s, t);
   endtask

   task automatic pop();
      send_item(FUNC_POP, 16'($urandom()), 8'($urandom()));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
   endtask

   task automatic write_window(input int w);
      wait_idle();
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= WIN_BITS'(w);
      do @(posedge clock); while (!csr_ch.ready);
      win = w;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Empties both lists: pops what is in order, otherwise fills the side list so that
   // a pop at full occupancy is forced to make progress.
   task automatic drain();
      while (SLOTS - free_cnt > 0) begin
         if ((ord_cnt > 0 && ord_seq[0] == exp_seq) || free_cnt == 0) pop();
         else push(exp_seq - 16'(win) - 16'd1, 8'($urandom()));
      end
   endtask

   always @(posedge clock) begin
      reorder_result want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report("result beat with no command outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status)
               report($sformatf("status %0d, want %0d", rsp_ch.status, want.status));
            if (rsp_ch.out_seq !== want.out_seq)
               report($sformatf("out_seq %0d, want %0d", rsp_ch.out_seq, want.out_seq));
            if (rsp_ch.out_tag !== want.out_tag)
               report($sformatf("out_tag %0d, want %0d", rsp_ch.out_tag, want.out_tag));
            if (rsp_ch.flushed !== want.flushed)
               report($sformatf("flushed %0d, want %0d", rsp_ch.flushed, want.flushed));
            if (rsp_ch.held !== want.held)
               report($sformatf("held %0d, want %0d", rsp_ch.held, want.held));
         end
      end
   end

   always @(negedge clock) rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

   // Extremes of the number space, wrap of the expected number, duplicate, late, side list.
   task automatic test_basic();
      push(16'hFFFF, 8'hFF);
      push(16'hFFFF, 8'h12);
      push(16'h0000, 8'h00);
      push(16'hFFFA, 8'h55);
      push(16'd4999, 8'hAA);
      pop();
      pop();
      pop();
      push(16'd3, 8'h33);
      pop();
      drain();
   endtask

   // Ordered list full with a gap at the expected number: refused push, then forced jump.
   task automatic test_full_head();
      logic [15:0] base;
      base = exp_seq;
      for (int i = 0; i < SLOTS; i++) push(base + 16'(2 + i), 8'($urandom()));
      push(base + 16'd40, 8'h01);
      pop();
      pop();
      drain();
   endtask

   // Side list holds every slot with an empty ordered list, so a pop places it all again.
   task automatic test_side_repush();
      logic [15:0] base;
      base = exp_seq + 16'd2000;
      for (int i = 0; i < SLOTS; i++) begin
         if (i == 5) push(base + 16'd12, 8'($urandom()));
         else if (i == 9) push(base - 16'd10, 8'($urandom()));
         else push(base + 16'(3 * i), 8'($urandom()));
      end
      pop();
      pop();
      drain();
   endtask

   task automatic test_random(input int n, input int w, input int tx_pct, input int rx_pct);
      int r;
      int span;
      write_window(w);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      span = (w < 48) ? w : 48;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 40) pop();
         else if (r < 75) push(exp_seq + 16'($urandom_range(0, span)), 8'($urandom()));
         else if (r < 88) push(exp_seq - 16'($urandom_range(1, 20)), 8'($urandom()));
         else push(16'($urandom()), 8'($urandom()));
      end
   endtask

   initial begin
      fail_count = 0;
      delivered_count = 0;
      repush_count = 0;
      side_count_total = 0;
      tx_idle_pct = 7;
      rx_idle_pct = 52;
      ord_cnt = 0;
      side_cnt = 0;
      free_cnt = SLOTS;
      exp_seq = '0;
      exp_valid = 1'b0;
      win = int'(WIN_RESET);
      req_ch.valid   <= 1'b0;
      req_ch.func    <= FUNC_PUSH;
      req_ch.seq_num <= '0;
      req_ch.tag     <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_basic();
      test_full_head();
      test_side_repush();
      test_random(150, 32767, 7, 52);
      test_random(140, 1, 52, 7);
      test_random(150, $urandom_range(16, 200), 0, 0);
      write_window(1024);
      test_random(10, 1024, 0, 0);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered pushes and pops over windows 1, 1024, 32767 and a random one:");
      $display("%0d packets delivered, %0d side-list beats, %0d full re-placements.",
               delivered_count, side_count_total, repush_count);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end
endmodule

// File: files.f
src/rsrb_pkg.sv
src/rsrb_ifaces.sv
src/rtp_sequence_reorder_buffer_unit.sv
src/rsrb_check.sv
dv/tb.sv
